>>> design/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

   localparam int UNIT_TICKS_W  = 16;
   localparam int HALF_PERIOD_W = 8;
   localparam int CSR_DATA_W    = 16;

   localparam logic [UNIT_TICKS_W-1:0]  UNIT_TICKS_RESET  = 16'd512;
   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 8'd8;

   // register indexes on the csr port
   localparam logic CSR_UNIT_TICKS  = 1'b0;
   localparam logic CSR_HALF_PERIOD = 1'b1;

   localparam logic       ACTION_SUBMIT = 1'b0;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   localparam logic [2:0] GAP_UNITS       = 3'd3;
   localparam logic [2:0] GAP_UNITS_SPACE = 3'd4;

   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic data_bit;
      logic busy_res;
      logic char_done;
   } rsp_type;

   // element count and dash map (bit k set = element k is a dash)
   typedef struct packed {
      logic [2:0] total;
      logic [4:0] pattern;
   } code_type;

   function automatic code_type code_lookup(input logic [7:0] c);
      code_type r;
      case (c)
         "A": r = '{3'd2, 5'b00010};
         "B": r = '{3'd4, 5'b00001};
         "C": r = '{3'd4, 5'b00101};
         "D": r = '{3'd3, 5'b00001};
         "E": r = '{3'd1, 5'b00000};
         "F": r = '{3'd4, 5'b00100};
         "G": r = '{3'd3, 5'b00011};
         "H": r = '{3'd4, 5'b00000};
         "I": r = '{3'd2, 5'b00000};
         "J": r = '{3'd4, 5'b01110};
         "K": r = '{3'd3, 5'b00101};
         "L": r = '{3'd4, 5'b00010};
         "M": r = '{3'd2, 5'b00011};
         "N": r = '{3'd2, 5'b00001};
         "O": r = '{3'd3, 5'b00111};
         "P": r = '{3'd4, 5'b00110};
         "Q": r = '{3'd4, 5'b01011};
         "R": r = '{3'd3, 5'b00010};
         "S": r = '{3'd3, 5'b00000};
         "T": r = '{3'd1, 5'b00001};
         "U": r = '{3'd3, 5'b00100};
         "V": r = '{3'd4, 5'b01000};
         "W": r = '{3'd3, 5'b00110};
         "X": r = '{3'd4, 5'b01001};
         "Y": r = '{3'd4, 5'b01101};
         "Z": r = '{3'd4, 5'b00011};
         "0": r = '{3'd5, 5'b11111};
         "1": r = '{3'd5, 5'b11110};
         "2": r = '{3'd5, 5'b11100};
         "3": r = '{3'd5, 5'b11000};
         "4": r = '{3'd5, 5'b10000};
         "5": r = '{3'd5, 5'b00000};
         "6": r = '{3'd5, 5'b00001};
         "7": r = '{3'd5, 5'b00011};
         "8": r = '{3'd5, 5'b00111};
         "9": r = '{3'd5, 5'b01111};
         default: r = '{3'd0, 5'b00000};
      endcase
      return r;
   endfunction

endpackage

>>> design/mck_core.sv
`timescale 1ns / 1ps

module mck_core
   import mck_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  req_type                  item,
   input  logic [UNIT_TICKS_W-1:0]  unit_ticks,
   input  logic [HALF_PERIOD_W-1:0] half_period,
   output rsp_type                  result
);

   logic                    busy_ff,    busy_in;
   logic [4:0]              pattern_ff, pattern_in;
   logic [2:0]              total_ff,   total_in;
   logic [2:0]              pos_ff,     pos_in;
   logic [1:0]              uie_ff,     uie_in;
   logic [2:0]              gap_ff,     gap_in;
   logic [UNIT_TICKS_W-1:0] tiu_ff,     tiu_in;
   logic [HALF_PERIOD_W-1:0] hpc_ff,    hpc_in;
   logic                    pin_ff,     pin_in;

   code_type                 code;
   logic [UNIT_TICKS_W-1:0]  ut;
   logic [HALF_PERIOD_W-1:0] hp;
   logic                     in_elem;
   logic                     dash;
   logic [1:0]               len;
   logic                     tone;
   logic [UNIT_TICKS_W-1:0]  tiu_inc;
   logic [HALF_PERIOD_W:0]   hpc_inc;
   logic [HALF_PERIOD_W-1:0] hpc_next;
   logic                     unit_end;
   logic [2:0]               gap_dec;
   logic                     done;
   logic                     acc;

   assign code    = code_lookup(item.char_code);
   assign ut      = (unit_ticks == '0) ? UNIT_TICKS_W'(1) : unit_ticks;
   assign hp      = (half_period == '0) ? HALF_PERIOD_W'(1) : half_period;
   assign in_elem = pos_ff < total_ff;
   assign dash    = in_elem && pattern_ff[pos_ff[2] ? 3'd4 : pos_ff];
   assign len     = dash ? 2'd3 : 2'd1;
   assign tone    = in_elem && (uie_ff < len);
   assign tiu_inc = tiu_ff + UNIT_TICKS_W'(1);
   assign hpc_inc = {1'b0, hpc_ff} + (HALF_PERIOD_W+1)'(1);
   assign hpc_next = (hpc_inc >= {1'b0, hp}) ? '0 : hpc_inc[HALF_PERIOD_W-1:0];
   // unit closes when the count reaches the limit or wraps to zero
   assign unit_end = (tiu_inc >= ut) || (tiu_inc == '0);
   assign gap_dec  = (gap_ff != 3'd0) ? gap_ff - 3'd1 : 3'd0;

   always_comb begin
      busy_in    = busy_ff;
      pattern_in = pattern_ff;
      total_in   = total_ff;
      pos_in     = pos_ff;
      uie_in     = uie_ff;
      gap_in     = gap_ff;
      tiu_in     = tiu_ff;
      hpc_in     = hpc_ff;
      pin_in     = pin_ff;
      done       = 1'b0;
      acc        = 1'b0;
      if (step_en) begin
         if (item.action == ACTION_SUBMIT) begin
            if (!busy_ff) begin
               acc        = 1'b1;
               busy_in    = 1'b1;
               pattern_in = code.pattern;
               total_in   = code.total;
               pos_in     = '0;
               uie_in     = '0;
               tiu_in     = '0;
               hpc_in     = '0;
               gap_in     = (item.char_code == CHAR_SPACE) ? GAP_UNITS_SPACE : GAP_UNITS;
            end
         end else if (busy_ff) begin
            tiu_in = tiu_inc;
            hpc_in = hpc_next;
            if (tone) begin
               if (hpc_next == hp - HALF_PERIOD_W'(1)) begin
                  pin_in = ~pin_ff;
               end
            end else begin
               pin_in = 1'b0;
            end
            if (unit_end) begin
               tiu_in = '0;
               hpc_in = '0;
               if (in_elem) begin
                  if (uie_ff >= len) begin
                     uie_in = '0;
                     pos_in = pos_ff + 3'd1;
                  end else begin
                     uie_in = uie_ff + 2'd1;
                  end
               end else begin
                  gap_in = gap_dec;
                  if (gap_dec == 3'd0) begin
                     busy_in    = 1'b0;
                     pattern_in = '0;
                     total_in   = '0;
                     pos_in     = '0;
                     uie_in     = '0;
                     done       = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pattern_ff <= '0;
         total_ff   <= '0;
         pos_ff     <= '0;
         uie_ff     <= '0;
         gap_ff     <= '0;
         tiu_ff     <= '0;
         hpc_ff     <= '0;
         pin_ff     <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         pattern_ff <= pattern_in;
         total_ff   <= total_in;
         pos_ff     <= pos_in;
         uie_ff     <= uie_in;
         gap_ff     <= gap_in;
         tiu_ff     <= tiu_in;
         hpc_ff     <= hpc_in;
         pin_ff     <= pin_in;
      end
   end

   assign result.accepted  = acc;
   assign result.data_bit  = pin_in;
   assign result.busy_res  = busy_in;
   assign result.char_done = done;

endmodule

>>> design/morse_code_keyer.sv
`timescale 1ns / 1ps

// Morse keyer paced by the radio's serial data clock. Each request word is
// either a character submit (A-Z, 0-9, space; anything else keys only the
// closing gap) or one data clock tick; every request word yields exactly one
// response word carrying accepted, the data pin level, busy and char_done.
// A submit is taken only while idle. Dots are one tone unit, dashes three,
// each followed by a silent unit; a character closes with three silent units
// (four for space). During tone the data bit toggles every tone_half_period
// ticks, restarting phase each unit. One word per clock is taken while the
// response side does not stall: a word is captured in the input register,
// runs through the keyer state update and lands in the response register.
// While a response word waits, the response register holds and the input
// register still takes one more word if it is empty; after that req_stall
// stays high until the response word is taken. csr writes (unit_ticks at
// index 0, tone_half_period at index 1) take effect at once; zero in either
// acts as one. Write them only while the keyer is idle.

module morse_code_keyer
   import mck_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [UNIT_TICKS_W-1:0]  unit_ticks_ff;
   logic [HALF_PERIOD_W-1:0] half_period_ff;

   // input register
   logic    s1_vld_ff, s1_vld_in;
   req_type s1_data_ff;

   // response register
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;

   logic    out_free;
   logic    step_en;
   rsp_type core_rsp;

   assign out_free  = !out_vld_ff || !rsp_stall;
   // input slot frees when its word moves on to the response register
   assign req_stall = s1_vld_ff && !out_free;
   assign step_en   = s1_vld_ff && out_free;

   assign s1_vld_in  = req_stall ? s1_vld_ff : req_valid;
   assign out_vld_in = out_free ? s1_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff  <= UNIT_TICKS_RESET;
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNIT_TICKS:  unit_ticks_ff  <= csr_wdata[UNIT_TICKS_W-1:0];
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[HALF_PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= core_rsp;
      end
   end

   mck_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .item        (s1_data_ff),
      .unit_ticks  (unit_ticks_ff),
      .half_period (half_period_ff),
      .result      (core_rsp)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> tb/sv/tb_morse_code_keyer.sv
`timescale 1ns / 1ps

// Self-checking bench for the Morse keyer. A sender task pushes request words
// through the valid/stall handshake and, on every accepted word, runs the
// keyer model below to queue the response word it must produce. A checker
// process pops that queue on every accepted response word.

module tb_morse_code_keyer;
   import mck_pkg::*;

   localparam logic ACTION_TICK  = ~ACTION_SUBMIT;
   localparam int   STALL_LIMIT  = 1000;   // cycles with no word moving
   localparam int   SETTLE_TICKS = 4;      // pipeline is two deep, plus margin

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   morse_code_keyer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Keyer model: own copy of config and keying state
   // ------------------------------------------------------------------
   // dot/dash strings for A-Z then 0-9
   string morse_table [36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....", "-....",
      "--...", "---..", "----."
   };
   string char_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

   logic [UNIT_TICKS_W-1:0]  unit_ticks_q  = UNIT_TICKS_RESET;
   logic [HALF_PERIOD_W-1:0] half_period_q = HALF_PERIOD_RESET;

   logic        keying_q = 1'b0;
   logic [4:0]  dash_map_q = '0;     // bit k set: element k is a dash
   logic [2:0]  elem_count_q = '0;
   logic [2:0]  elem_idx_q = '0;
   logic [1:0]  unit_idx_q = '0;     // unit within the current element
   logic [2:0]  gap_left_q = '0;     // closing silent units still to key
   logic [15:0] tick_q = '0;         // ticks into the current unit
   logic [7:0]  phase_q = '0;        // tick_q modulo the half period
   logic        pin_q = 1'b0;

   rsp_type expected_rsp [$];
   int      mismatch_count = 0;
   int      item_count = 0;
   bit      idle_on = 1'b1;          // random idling on both sides

   function automatic void load_char(input logic [7:0] c);
      string s;
      int    idx;
      idx = -1;
      if (c >= "A" && c <= "Z")
         idx = int'(c - "A");
      else if (c >= "0" && c <= "9")
         idx = 26 + int'(c - "0");
      dash_map_q   = '0;
      elem_count_q = '0;
      if (idx >= 0) begin
         s = morse_table[idx];
         for (int k = 0; k < s.len(); k++)
            if (s[k] == "-") dash_map_q[k] = 1'b1;
         elem_count_q = 3'(s.len());
      end
      gap_left_q = (c == CHAR_SPACE) ? GAP_UNITS_SPACE : GAP_UNITS;
      elem_idx_q = '0;
      unit_idx_q = '0;
      tick_q     = '0;
      phase_q    = '0;
      keying_q   = 1'b1;
   endfunction

   // Applies one request word to the model and returns the response word.
   function automatic rsp_type keyer_step(input req_type w);
      rsp_type r;
      int      ut;
      int      hp;
      int      len;
      bit      in_elem;
      bit      tone;
      bit      done;
      r    = '0;
      done = 1'b0;
      if (w.action == ACTION_SUBMIT) begin
         // submit while busy is dropped
         if (!keying_q) begin
            load_char(w.char_code);
            r.accepted = 1'b1;
         end
      end else if (keying_q) begin
         // zero in either register behaves as one
         ut = (unit_ticks_q == 0) ? 1 : unit_ticks_q;
         hp = (half_period_q == 0) ? 1 : half_period_q;
         in_elem = elem_idx_q < elem_count_q;
         len = (in_elem && dash_map_q[elem_idx_q]) ? 3 : 1;
         tone = in_elem && (unit_idx_q < len);

         tick_q  = tick_q + 16'd1;
         phase_q = (phase_q + 1 >= hp) ? 8'd0 : phase_q + 8'd1;

         if (tone) begin
            if (phase_q == hp - 1) pin_q = ~pin_q;
         end else begin
            pin_q = 1'b0;
         end

         // unit boundary (tick_q == 0 only after 16-bit wrap)
         if (tick_q >= ut || tick_q == 0) begin
            tick_q  = '0;
            phase_q = '0;
            if (in_elem) begin
               if (unit_idx_q >= len) begin
                  unit_idx_q = '0;
                  elem_idx_q = elem_idx_q + 3'd1;
               end else begin
                  unit_idx_q = unit_idx_q + 2'd1;
               end
            end else begin
               if (gap_left_q > 0) gap_left_q = gap_left_q - 3'd1;
               if (gap_left_q == 0) begin
                  keying_q     = 1'b0;
                  dash_map_q   = '0;
                  elem_count_q = '0;
                  elem_idx_q   = '0;
                  unit_idx_q   = '0;
                  done         = 1'b1;
               end
            end
         end
      end
      r.data_bit  = pin_q;
      r.busy_res  = keying_q;
      r.char_done = done;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, initial drive values
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_UNIT_TICKS;
      csr_wdata <= '0;
   end

   // ------------------------------------------------------------------
   // Request side: one word per call, random gap in front of it
   // ------------------------------------------------------------------
   task automatic send_word(input logic act, input logic [7:0] code);
      req_type w;
      int      gap;
      w.action    = act;
      w.char_code = code;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      expected_rsp.push_back(keyer_step(w));
      item_count++;
   endtask

   // Hold off the sender until every queued response word is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_UNIT_TICKS)
         unit_ticks_q = value;
      else
         half_period_q = value[7:0];
   endtask

   // Submit one character and tick until the model says it is keyed out.
   // noise_pct: chance per tick slot of a stray submit while busy.
   task automatic run_char(input logic [7:0] c, input int noise_pct);
      logic [7:0] junk;
      send_word(ACTION_SUBMIT, c);
      while (keying_q) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            junk = 8'($urandom);
            send_word(ACTION_SUBMIT, junk);
         end else begin
            send_word(ACTION_TICK, 8'h00);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall before each word, then checking
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = idle_on ? $urandom_range(0, 11) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid || reset) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response word %b", rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.accepted  !== want.accepted ||
                rsp_data.data_bit  !== want.data_bit ||
                rsp_data.busy_res  !== want.busy_res ||
                rsp_data.char_done !== want.char_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"rsp mismatch: exp acc=%b bit=%b busy=%b done=%b,",
                            " got acc=%b bit=%b busy=%b done=%b"},
                           want.accepted, want.data_bit, want.busy_res, want.char_done,
                           rsp_data.accepted, rsp_data.data_bit, rsp_data.busy_res,
                           rsp_data.char_done);
            end
         end
      end
   end

   // Watchdog: trips when no word moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("morse_code_keyer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // ticks while idle must leave everything low
   task automatic test_idle_ticks();
      repeat (3) send_word(ACTION_TICK, 8'h00);
   endtask

   // zero in both registers acts as one; stray submit mid-character
   task automatic test_zero_registers();
      write_reg(CSR_UNIT_TICKS, 16'd0);
      write_reg(CSR_HALF_PERIOD, 16'h0000);
      send_word(ACTION_SUBMIT, "E");
      send_word(ACTION_TICK, 8'h00);
      send_word(ACTION_SUBMIT, "T");   // dropped, still busy
      while (keying_q) send_word(ACTION_TICK, 8'h00);
   endtask

   // space keys four silent units, unknown codes only the closing gap
   task automatic test_space_and_unknown();
      write_reg(CSR_UNIT_TICKS, 16'd1);
      write_reg(CSR_HALF_PERIOD, 16'h00FF);
      run_char(CHAR_SPACE, 0);
      run_char("a", 0);
      run_char(8'hFF, 0);
   endtask

   // mostly well-formed characters at small unit lengths, some noise
   task automatic test_random_traffic();
      int         pick;
      int         ut;
      logic [7:0] hi;
      logic [7:0] c;
      while (item_count < 560) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            ut = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
            hi = 8'($urandom);
            write_reg(CSR_UNIT_TICKS, 16'(ut));
            write_reg(CSR_HALF_PERIOD, {hi, 8'($urandom_range(0, ut + 2))});
         end
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_word(ACTION_TICK, 8'h00);
         pick = $urandom_range(0, 9);
         if (pick < 7)
            c = char_set[$urandom_range(0, 35)];
         else if (pick == 7)
            c = CHAR_SPACE;
         else
            c = 8'($urandom);
         run_char(c, 8);
      end
   endtask

   // longest unit and half period: character stays open to the end
   task automatic test_long_unit();
      logic [7:0] junk;
      idle_on = 1'b1;
      write_reg(CSR_UNIT_TICKS, 16'hFFFF);
      write_reg(CSR_HALF_PERIOD, 16'hFFFF);
      send_word(ACTION_SUBMIT, "T");
      repeat (300) begin
         if ($urandom_range(0, 9) == 0) begin
            junk = 8'($urandom);
            send_word(ACTION_SUBMIT, junk);
         end else begin
            send_word(ACTION_TICK, 8'h00);
         end
      end
   endtask

   initial begin : run_tests
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_zero_registers();
      test_space_and_unknown();
      test_random_traffic();
      test_long_unit();

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("morse_code_keyer test passed");
      else
         $display("morse_code_keyer test failed");
      $finish;
   end

endmodule

>>> files.f
design/mck_pkg.sv
design/mck_core.sv
design/morse_code_keyer.sv
tb/sv/tb_morse_code_keyer.sv
